// File: rtl/npcs_pkg.sv
`timescale 1ns / 1ps
// Package for the nearest palette colour search block.
// Holds the word types, register and operation codes, and the colour helpers
// shared by the interfaces, the scan engine and the top level.
package npcs_pkg;

  // Distance of one palette entry: three 8-bit differences summed
  localparam int unsigned DIST_W = 10;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic {
    BANK_IMAGE  = 1'b0,
    BANK_SYSTEM = 1'b1
  } bank_e;

  typedef enum logic {
    CFG_FULL_SCREEN     = 1'b0,
    CFG_PALETTE_PRESENT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    op_e        operation;
    bank_e      bank;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [15:0] color_code;
  } out_word_t;

  // Palette write towards the scan engine
  typedef struct packed {
    logic       en;
    bank_e      bank;
    logic [7:0] idx;
    rgb_t       color;
  } pal_wr_t;

  // Search request towards the scan engine
  typedef struct packed {
    logic  start;
    bank_e bank;
    rgb_t  color;
  } scan_req_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DIST_W-1:0] color_dist(input rgb_t a, input rgb_t b);
    color_dist = DIST_W'(abs_diff(a.red, b.red))
               + DIST_W'(abs_diff(a.green, b.green))
               + DIST_W'(abs_diff(a.blue, b.blue));
  endfunction

  // Pack a triple into a 5-6-5 word
  function automatic logic [15:0] pack_rgb565(input rgb_t c);
    pack_rgb565 = {c.red[7:3], c.green[7:2], c.blue[7:3]};
  endfunction

endpackage

// File: rtl/npcs_in_if.sv
`timescale 1ns / 1ps
// Input channel of the nearest palette colour search block.
// Carries one in_word_t per handshake; depends on npcs_pkg.
interface npcs_in_if;
  logic               valid;
  logic               ready;
  npcs_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/npcs_out_if.sv
`timescale 1ns / 1ps
// Result channel of the nearest palette colour search block.
// Carries one out_word_t per handshake; depends on npcs_pkg.
interface npcs_out_if;
  logic                valid;
  logic                ready;
  npcs_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/npcs_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the nearest palette colour search block.
// Carries a register index and one data bit; depends on npcs_pkg.
interface npcs_cfg_if;
  logic               valid;
  logic               ready;
  npcs_pkg::cfg_reg_e index;
  logic               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/npcs_scan.sv
`timescale 1ns / 1ps
// Palette memories and scan engine of the nearest palette colour search block.
// Reads one entry per cycle, scores it and keeps the lowest index of the
// smallest distance; depends on npcs_pkg.
module npcs_scan #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  localparam int unsigned IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  npcs_pkg::pal_wr_t   wr_i,
  input  npcs_pkg::scan_req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [IdxW-1:0]     index_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_ENTRIES - 1);

  npcs_pkg::rgb_t image_mem [PALETTE_ENTRIES];
  npcs_pkg::rgb_t system_mem [PALETTE_ENTRIES];
  npcs_pkg::rgb_t image_rd_q, system_rd_q;

  logic                       scan_q;
  logic [IdxW-1:0]            cnt_q;
  npcs_pkg::bank_e            bank_q;
  npcs_pkg::rgb_t             target_q;

  logic                       v1_q, last1_q;
  logic [IdxW-1:0]            idx1_q;
  logic                       v2_q, last2_q;
  logic [IdxW-1:0]            idx2_q;
  logic [npcs_pkg::DIST_W-1:0] dist2_q;
  logic [npcs_pkg::DIST_W-1:0] best_dist_q;
  logic [IdxW-1:0]            best_idx_q;
  logic                       done_q;

  npcs_pkg::rgb_t             entry;
  logic                       take;

  // Write and read the palettes; writes only arrive while the engine is idle
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.bank == npcs_pkg::BANK_IMAGE)) begin
      image_mem[wr_i.idx[IdxW-1:0]] <= wr_i.color;
    end
    if (wr_i.en && (wr_i.bank == npcs_pkg::BANK_SYSTEM)) begin
      system_mem[wr_i.idx[IdxW-1:0]] <= wr_i.color;
    end
    if (scan_q) begin
      image_rd_q  <= image_mem[cnt_q];
      system_rd_q <= system_mem[cnt_q];
    end
  end

  // Sweep the read address over every entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      scan_q <= 1'b1;
      cnt_q  <= '0;
    end else if (scan_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastIdx) begin
        scan_q <= 1'b0;
      end
    end
  end

  // Latch the searched colour and bank
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      bank_q   <= req_i.bank;
      target_q <= req_i.color;
    end
  end

  // Stage valids follow the read data down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= scan_q;
      v2_q   <= v1_q;
      done_q <= v2_q && last2_q;
    end
  end

  assign entry = (bank_q == npcs_pkg::BANK_SYSTEM) ? system_rd_q : image_rd_q;

  // Score the entry that came out of memory
  always_ff @(posedge clk_i) begin
    idx1_q  <= cnt_q;
    last1_q <= (cnt_q == LastIdx);
    idx2_q  <= idx1_q;
    last2_q <= last1_q;
    dist2_q <= npcs_pkg::color_dist(entry, target_q);
  end

  // Keep the first entry, then only strictly closer ones
  assign take = v2_q && ((idx2_q == '0) || (dist2_q < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q <= dist2_q;
      best_idx_q  <= idx2_q;
    end
  end

  assign busy_o  = scan_q || v1_q || v2_q || done_q;
  assign done_o  = done_q;
  assign index_o = best_idx_q;

endmodule

// File: rtl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Nearest palette colour search: a palette write is taken and gives no
// result. A search in full-screen mode, or in windowed mode with a palette,
// sweeps the selected palette through its memory read port at one entry per
// cycle; the single read port per palette sets that rate. A windowed search
// without a palette packs the colour into RGB565. One item is worked on at a
// time; the next is accepted as soon as the previous result has moved into
// the output register, even while that word still waits to be taken. Every
// entry of a palette must be written before that palette is searched.
// Depends on npcs_pkg, the three channel interfaces and npcs_scan.
module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  npcs_in_if.sink    in_i,
  npcs_out_if.source out_o,
  npcs_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic                   full_screen_q;
  logic                   palette_present_q;
  logic [15:0]            res_q, res_d;
  logic                   out_valid_q;
  npcs_pkg::out_word_t    out_q;

  logic                   in_fire;
  logic                   out_free;
  logic                   in_range;
  npcs_pkg::rgb_t         in_color;
  npcs_pkg::pal_wr_t      pal_wr;
  npcs_pkg::scan_req_t    scan_req;
  logic                   scan_busy;
  logic                   scan_done;
  logic [IdxW-1:0]        scan_index;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_screen_q     <= 1'b0;
      palette_present_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        npcs_pkg::CFG_FULL_SCREEN:     full_screen_q     <= cfg_i.data;
        npcs_pkg::CFG_PALETTE_PRESENT: palette_present_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input handshake and word decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_range   = ({1'b0, in_i.data.entry_index} < 9'(PALETTE_ENTRIES));
  assign in_color   = '{red: in_i.data.red, green: in_i.data.green, blue: in_i.data.blue};

  // Drop writes beyond the palette
  always_comb begin
    pal_wr.en    = in_fire && (in_i.data.operation == npcs_pkg::OP_WRITE) && in_range;
    pal_wr.bank  = in_i.data.bank;
    pal_wr.idx   = in_i.data.entry_index;
    pal_wr.color = in_color;
  end

  always_comb begin
    scan_req.start = in_fire && (in_i.data.operation == npcs_pkg::OP_SEARCH)
                     && (full_screen_q || palette_present_q);
    scan_req.bank  = full_screen_q ? npcs_pkg::BANK_IMAGE : npcs_pkg::BANK_SYSTEM;
    scan_req.color = in_color;
  end

  npcs_scan #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (pal_wr),
    .req_i  (scan_req),
    .busy_o (scan_busy),
    .done_o (scan_done),
    .index_o(scan_index)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // Sequence one item: scan or pack, then hold until the output is free
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.data.operation == npcs_pkg::OP_SEARCH)) begin
          if (scan_req.start) begin
            state_d = ST_SCAN;
          end else begin
            res_d   = npcs_pkg::pack_rgb565(in_color);
            state_d = ST_HOLD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_d   = 16'(scan_index);
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Output register: load from the held result, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_HOLD) && out_free) begin
      out_q.color_code <= res_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Checks on the sequencing
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_done_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == ST_SCAN))
    else $error("scan result outside a search");

  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_wr.en |-> !scan_busy)
    else $error("palette write while scan engine busy");

  a_start_enters_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_req.start |=> (state_q == ST_SCAN) && scan_busy)
    else $error("search start did not enter scan");

endmodule
